// File: src/sap_pkg.sv
package sap_pkg;

   // fraction bits of rate_gain (Q4.F) and round_bias (Q.F)
   localparam int FRAC_BITS = 12;

   localparam int VAL_W   = 16;
   localparam int STEP_W  = 15;
   localparam int GAIN_W  = 16;
   localparam int BIAS_W  = 14;
   localparam int PROD_W  = STEP_W + GAIN_W;   // 31
   localparam int SUM_W   = PROD_W + 2;        // 33, signed
   localparam int DIV_CNT_W = $clog2(VAL_W);
   localparam int MUL_CNT_W = $clog2(VAL_W / 2);

   // config register indexes
   localparam logic [2:0] REG_DIVISOR    = 3'd0;
   localparam logic [2:0] REG_MAX_STEP   = 3'd1;
   localparam logic [2:0] REG_MIN_STEP   = 3'd2;
   localparam logic [2:0] REG_RATE_GAIN  = 3'd3;
   localparam logic [2:0] REG_ROUND_BIAS = 3'd4;

   localparam logic signed [VAL_W-1:0]  DIVISOR_RST    = 16'sd1;
   localparam logic [STEP_W-1:0]        MAX_STEP_RST   = 15'd32767;
   localparam logic [STEP_W-1:0]        MIN_STEP_RST   = 15'd0;
   localparam logic [GAIN_W-1:0]        RATE_GAIN_RST  = 16'd4096;
   localparam logic signed [BIAS_W-1:0] ROUND_BIAS_RST = 14'sd2048;

   typedef struct packed {
      logic                    req_type;
      logic signed [VAL_W-1:0] target;
   } req_word_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] new_value;
      logic signed [VAL_W-1:0] difference;
      logic                    at_target;
      logic                    config_error;
   } rsp_word_type;

   // start/done pair between the sequencer and a serial unit
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

endpackage

// File: src/sap_div.sv
// Bit-serial restoring divider, unsigned magnitudes, one quotient bit per cycle.
module sap_div (
   input  logic                                clock,
   input  logic                                reset,
   input  sap_pkg::unit_ctl_type               ctl,
   input  logic [sap_pkg::VAL_W-1:0]           dividend,
   input  logic [sap_pkg::VAL_W-1:0]           divisor,
   output logic [sap_pkg::VAL_W-1:0]           quotient,
   output sap_pkg::unit_sts_type               sts
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [sap_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [sap_pkg::VAL_W-1:0]         rem_ff, rem_in;
   logic [sap_pkg::VAL_W-1:0]         quot_ff, quot_in;
   logic [sap_pkg::VAL_W-1:0]         dsr_ff, dsr_in;
   logic [sap_pkg::VAL_W:0]           trial;
   logic [sap_pkg::VAL_W:0]           diff_w;

   assign trial  = {rem_ff, quot_ff[sap_pkg::VAL_W-1]};
   assign diff_w = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = diff_w[sap_pkg::VAL_W-1:0];
            quot_in = {quot_ff[sap_pkg::VAL_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[sap_pkg::VAL_W-1:0];
            quot_in = {quot_ff[sap_pkg::VAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sap_pkg::DIV_CNT_W'(sap_pkg::VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient = quot_ff;
   assign sts.done = done_ff;

endmodule

// File: src/sap_mul.sv
// Serial shift-add multiplier, two multiplier bits (one radix-4 digit) per cycle.
module sap_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  sap_pkg::unit_ctl_type               ctl,
   input  logic [sap_pkg::STEP_W-1:0]          mcand_a,
   input  logic [sap_pkg::GAIN_W-1:0]          gain,
   output logic [sap_pkg::PROD_W-1:0]          product,
   output sap_pkg::unit_sts_type               sts
);

   localparam int LO_W = sap_pkg::STEP_W + 1;   // multiplier padded to whole digits
   localparam int HI_W = sap_pkg::GAIN_W + 2;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [sap_pkg::MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [HI_W-1:0]                   hi_ff, hi_in;
   logic [LO_W-1:0]                   lo_ff, lo_in;
   logic [sap_pkg::GAIN_W-1:0]        g_ff, g_in;
   logic [HI_W-1:0]                   g3_ff, g3_in;
   logic [HI_W-1:0]                   pp;
   logic [HI_W-1:0]                   acc;

   always_comb begin
      unique case (lo_ff[1:0])
         2'd0:    pp = '0;
         2'd1:    pp = HI_W'(g_ff);
         2'd2:    pp = HI_W'({g_ff, 1'b0});
         default: pp = g3_ff;
      endcase
   end

   assign acc = hi_ff + pp;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      g_in    = g_ff;
      g3_in   = g3_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = {1'b0, mcand_a};
         g_in    = gain;
         g3_in   = HI_W'(gain) + HI_W'({gain, 1'b0});
      end else if (busy_ff) begin
         hi_in  = {2'b00, acc[HI_W-1:2]};
         lo_in  = {acc[1:0], lo_ff[LO_W-1:2]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sap_pkg::MUL_CNT_W'(LO_W / 2 - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      g_ff  <= g_in;
      g3_ff <= g3_in;
   end

   assign product = {hi_ff[sap_pkg::PROD_W-LO_W-1:0], lo_ff};
   assign sts.done = done_ff;

endmodule

// File: src/s16_smooth_approach_limited.sv
// A step word runs S_DECIDE, S_DIV on the bit-serial divider, S_SEL, S_MUL on the
// radix-4 multiplier, then S_BIAS, S_SCALE, S_ADD and S_OUT; a load, a zero-divisor
// step or a step already at target goes from S_DECIDE straight to S_OUT. The next word
// is accepted in the cycle after the result is registered, so no new word is taken
// while one is in progress; a result still stalled holds the next.
// Sync active-high reset: value 0, divisor 1, max 32767, min 0, gain 1.0, bias 0.5.
module s16_smooth_approach_limited (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sap_pkg::req_word_type       req_word,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sap_pkg::rsp_word_type       rsp_word,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int W  = sap_pkg::VAL_W;
   localparam int SW = sap_pkg::STEP_W;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_SEL    = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_BIAS   = 4'd5;
   localparam logic [3:0] S_SCALE  = 4'd6;
   localparam logic [3:0] S_ADD    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   // ---------------------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------------------
   logic signed [W-1:0]              divisor_ff;
   logic [SW-1:0]                    max_step_ff;
   logic [SW-1:0]                    min_step_ff;
   logic [sap_pkg::GAIN_W-1:0]       rate_gain_ff;
   logic signed [sap_pkg::BIAS_W-1:0] round_bias_ff;
   logic                             csr_wr;
   logic [2:0]                       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff    <= sap_pkg::DIVISOR_RST;
         max_step_ff   <= sap_pkg::MAX_STEP_RST;
         min_step_ff   <= sap_pkg::MIN_STEP_RST;
         rate_gain_ff  <= sap_pkg::RATE_GAIN_RST;
         round_bias_ff <= sap_pkg::ROUND_BIAS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            sap_pkg::REG_DIVISOR:    divisor_ff    <= csr_pwdata[W-1:0];
            sap_pkg::REG_MAX_STEP:   max_step_ff   <= csr_pwdata[SW-1:0];
            sap_pkg::REG_MIN_STEP:   min_step_ff   <= csr_pwdata[SW-1:0];
            sap_pkg::REG_RATE_GAIN:  rate_gain_ff  <= csr_pwdata[sap_pkg::GAIN_W-1:0];
            sap_pkg::REG_ROUND_BIAS: round_bias_ff <= csr_pwdata[sap_pkg::BIAS_W-1:0];
            default: ;  // unmapped, dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sap_pkg::REG_DIVISOR:    csr_prdata = 32'(unsigned'(divisor_ff));
         sap_pkg::REG_MAX_STEP:   csr_prdata = 32'(max_step_ff);
         sap_pkg::REG_MIN_STEP:   csr_prdata = 32'(min_step_ff);
         sap_pkg::REG_RATE_GAIN:  csr_prdata = 32'(rate_gain_ff);
         sap_pkg::REG_ROUND_BIAS: csr_prdata = 32'(unsigned'(round_bias_ff));
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath state
   // ---------------------------------------------------------------------------
   logic [3:0]                       state_ff, state_in;
   logic signed [W-1:0]              cur_ff, cur_in;        // current_value
   logic                             load_ff, load_in;
   logic signed [W-1:0]              tgt_ff, tgt_in;
   logic signed [W-1:0]              diff_ff, diff_in;
   logic                             err_ff, err_in;
   logic signed [W-1:0]              res_ff, res_in;        // value after the word
   logic                             band_ff, band_in;      // inside min band
   logic                             neg_ff, neg_in;        // final step sign flip
   logic [SW-1:0]                    mag_ff, mag_in;        // unscaled step magnitude
   logic signed [sap_pkg::SUM_W-1:0] sum_ff, sum_in;        // scaled step, Q.F
   logic signed [W-1:0]              step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sap_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   // serial units
   sap_pkg::unit_ctl_type            div_ctl, mul_ctl;
   sap_pkg::unit_sts_type            div_sts, mul_sts;
   logic [W-1:0]                     div_quot;
   logic [sap_pkg::PROD_W-1:0]       mul_prod;
   logic [W-1:0]                     diff_mag, dsr_mag;

   assign diff_mag = diff_ff[W-1] ? W'(-diff_ff) : W'(diff_ff);
   assign dsr_mag  = divisor_ff[W-1] ? W'(-divisor_ff) : W'(divisor_ff);

   sap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (diff_mag),
      .divisor  (dsr_mag),
      .quotient (div_quot),
      .sts      (div_sts)
   );

   // multiplicand taken as it is chosen, in the same cycle as the start
   sap_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mul_ctl),
      .mcand_a  (mag_in),
      .gain     (rate_gain_ff),
      .product  (mul_prod),
      .sts      (mul_sts)
   );

   // ---------------------------------------------------------------------------
   // Step selection: signed quotient, band test, clamp to +/- max_step
   // ---------------------------------------------------------------------------
   logic signed [W-1:0]  q_s;
   logic signed [W:0]    q_x, min_x, max_x;
   logic signed [W:0]    s_clamp;
   logic                 out_band;

   assign q_s   = (diff_ff[W-1] ^ divisor_ff[W-1]) ? W'(-div_quot) : W'(div_quot);
   assign q_x   = (W+1)'(q_s);
   assign min_x = signed'({2'b00, min_step_ff});
   assign max_x = signed'({2'b00, max_step_ff});
   assign out_band = (q_x > min_x) || (q_x < -min_x);

   always_comb begin
      s_clamp = q_x;
      if (q_x > max_x) begin
         s_clamp = max_x;
      end
      if (q_x < -max_x) begin
         s_clamp = -max_x;
      end
   end

   // ---------------------------------------------------------------------------
   // Scaling tail: |m| >> F, sign applied, then add and snap
   // ---------------------------------------------------------------------------
   logic [sap_pkg::SUM_W-1:0] sum_abs;
   logic [W-1:0]              scaled_mag;
   logic signed [W-1:0]       new_val;
   logic signed [W-1:0]       rest;

   assign sum_abs    = sum_ff[sap_pkg::SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign scaled_mag = sum_abs[sap_pkg::FRAC_BITS +: W];
   assign new_val    = cur_ff + step_ff;
   assign rest       = tgt_ff - new_val;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      load_in      = load_ff;
      tgt_in       = tgt_ff;
      diff_in      = diff_ff;
      err_in       = err_ff;
      res_in       = res_ff;
      band_in      = band_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      div_ctl.start = 1'b0;
      mul_ctl.start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               load_in  = req_word.req_type;
               tgt_in   = req_word.target;
               diff_in  = req_word.target - cur_ff;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            err_in = 1'b0;
            res_in = cur_ff;
            if (load_ff) begin
               res_in   = tgt_ff;
               state_in = S_OUT;
            end else if (divisor_ff == '0) begin
               err_in   = 1'b1;
               state_in = S_OUT;
            end else if (diff_ff == '0) begin
               state_in = S_OUT;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            // outside band: clamped quotient; inside: min_step toward target.
            // A zero step (clamped or min_step) carries the negative bias,
            // hence the extra flip.
            if (out_band) begin
               band_in = 1'b0;
               neg_in  = s_clamp[W] | (s_clamp == '0);
               mag_in  = s_clamp[W] ? SW'(-s_clamp) : SW'(s_clamp);
            end else begin
               band_in = 1'b1;
               neg_in  = (min_step_ff == '0) ^ diff_ff[W-1];
               mag_in  = min_step_ff;
            end
            mul_ctl.start = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            if (mul_sts.done) begin
               state_in = S_BIAS;
            end
         end
         S_BIAS: begin
            sum_in   = signed'({2'b00, mul_prod}) + sap_pkg::SUM_W'(round_bias_ff);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            step_in  = (neg_ff ^ sum_ff[sap_pkg::SUM_W-1]) ? W'(-scaled_mag) : W'(scaled_mag);
            state_in = S_ADD;
         end
         S_ADD: begin
            res_in = new_val;
            // snap when the minimum step reaches or crosses the target
            if (band_ff) begin
               if (!diff_ff[W-1] && (rest <= 0)) begin
                  res_in = tgt_ff;
               end
               if (diff_ff[W-1] && (rest >= 0)) begin
                  res_in = tgt_ff;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cur_in                   = res_ff;
               rsp_valid_in             = 1'b1;
               rsp_word_in.new_value    = res_ff;
               rsp_word_in.difference   = diff_ff;
               rsp_word_in.at_target    = (res_ff == tgt_ff);
               rsp_word_in.config_error = err_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      load_ff     <= load_in;
      tgt_ff      <= tgt_in;
      diff_ff     <= diff_in;
      err_ff      <= err_in;
      res_ff      <= res_in;
      band_ff     <= band_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      sum_ff      <= sum_in;
      step_ff     <= step_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: verif/s16_smooth_approach_limited_tb.sv
`timescale 1ns / 1ps

module s16_smooth_approach_limited_tb;

   // request kinds carried in req_word.req_type
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   localparam int IDLE_PCT    = 18;     // percent of cycles/words with a bubble or stall
   localparam int PHASE_COUNT = 8;      // register settings visited by the random part
   localparam int PHASE_WORDS = 80;     // request words per setting
   localparam int PRINT_LIMIT = 50;     // mismatch lines printed before going quiet

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   sap_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   sap_pkg::rsp_word_type rsp_word;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [4:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow of the block: tracked value plus a copy of every register
   logic signed [15:0]  tracked_value;
   logic signed [15:0]  cfg_divisor;
   logic [14:0]         cfg_max_step;
   logic [14:0]         cfg_min_step;
   logic [15:0]         cfg_rate_gain;
   logic signed [13:0]  cfg_round_bias;

   // outcome of every accepted request word, oldest first
   sap_pkg::rsp_word_type approach_q[$];

   int                  fail_count;
   bit                  no_idle;        // both sides run flat out while set

   s16_smooth_approach_limited uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Approach arithmetic, done in 64-bit signed and wrapped to 16 bits
   // ------------------------------------------------------------------
   function automatic longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
   endfunction

   // gain in Q4.F, bias pushed away from zero (a zero step counts as negative),
   // then truncation toward zero; longint division truncates the same way
   function automatic longint scaled_step(longint s);
      longint sum;
      sum = s * longint'(cfg_rate_gain)
            + ((s < 1) ? -longint'(cfg_round_bias) : longint'(cfg_round_bias));
      return wrap16(sum / (longint'(1) << sap_pkg::FRAC_BITS));
   endfunction

   // result of one request word; advances tracked_value
   function automatic sap_pkg::rsp_word_type approach_next(sap_pkg::req_word_type w);
      longint                tgt;
      longint                cur;
      longint                diff;
      longint                s;
      longint                band;
      longint                clamp;
      sap_pkg::rsp_word_type r;
      tgt   = longint'($signed(w.target));
      cur   = tracked_value;
      band  = cfg_min_step;
      clamp = cfg_max_step;
      diff  = wrap16(tgt - cur);
      r     = '0;
      if (w.req_type == REQ_LOAD) begin
         cur = tgt;
      end else if (cfg_divisor == 0) begin
         r.config_error = 1'b1;
      end else if (cur != tgt) begin
         // -32768 / -1 wraps back to -32768 here
         s = wrap16(diff / longint'(cfg_divisor));
         if (s > band || s < -band) begin
            if (s > clamp) s = clamp;
            if (s < -clamp) s = -clamp;
            cur = wrap16(cur + scaled_step(s));
         end else begin
            // inside the band: fixed step toward the target, snap on overshoot
            s = scaled_step(band);
            if (diff >= 0) begin
               cur = wrap16(cur + s);
               if (wrap16(tgt - cur) <= 0) cur = tgt;
            end else begin
               cur = wrap16(cur - s);
               if (wrap16(tgt - cur) >= 0) cur = tgt;
            end
         end
      end
      tracked_value  = cur[15:0];
      r.new_value    = cur[15:0];
      r.difference   = diff[15:0];
      r.at_target    = (cur == tgt);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall, compare each accepted word
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || no_idle)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      sap_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (approach_q.size() == 0) begin
            report_mismatch("unrequested result word", rsp_word, 0);
         end else begin
            want = approach_q.pop_front();
            if (rsp_word.new_value !== want.new_value)
               report_mismatch("new_value", rsp_word.new_value, want.new_value);
            if (rsp_word.difference !== want.difference)
               report_mismatch("difference", rsp_word.difference, want.difference);
            if (rsp_word.at_target !== want.at_target)
               report_mismatch("at_target", rsp_word.at_target, want.at_target);
            if (rsp_word.config_error !== want.config_error)
               report_mismatch("config_error", rsp_word.config_error, want.config_error);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Valid stays high across back-to-back words; a bubble lowers it so
   // that gaps land anywhere in a step word's sequence.
   task automatic send_word(logic kind, logic signed [15:0] tgt);
      sap_pkg::req_word_type w;
      w.req_type = kind;
      w.target   = tgt;
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      approach_q.push_back(approach_next(w));
   endtask

   // drop valid and let every outstanding result come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (approach_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   task automatic csr_read_check(logic [2:0] idx, logic [31:0] want);
      logic [31:0] mask;
      case (idx)
         sap_pkg::REG_MAX_STEP, sap_pkg::REG_MIN_STEP: mask = 32'h0000_7FFF;
         sap_pkg::REG_ROUND_BIAS:                      mask = 32'h0000_3FFF;
         default:                                      mask = 32'h0000_FFFF;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (want & mask))
         report_mismatch("register readback", csr_prdata & mask, want & mask);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // only while idle: drains the block first, then writes and reads back
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         sap_pkg::REG_DIVISOR:    cfg_divisor    = value[15:0];
         sap_pkg::REG_MAX_STEP:   cfg_max_step   = value[14:0];
         sap_pkg::REG_MIN_STEP:   cfg_min_step   = value[14:0];
         sap_pkg::REG_RATE_GAIN:  cfg_rate_gain  = value[15:0];
         sap_pkg::REG_ROUND_BIAS: cfg_round_bias = value[13:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read_check(idx, value);
   endtask

   task automatic apply_settings(logic [31:0] div, logic [31:0] max_s, logic [31:0] min_s,
                                 logic [31:0] gain, logic [31:0] bias);
      csr_write(sap_pkg::REG_DIVISOR, div);
      csr_write(sap_pkg::REG_MAX_STEP, max_s);
      csr_write(sap_pkg::REG_MIN_STEP, min_s);
      csr_write(sap_pkg::REG_RATE_GAIN, gain);
      csr_write(sap_pkg::REG_ROUND_BIAS, bias);
   endtask

   // the rails, 0 or -1, near the tracked value, or anything at all
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         4, 5, 6: return tracked_value + 16'($urandom_range(0, 600)) - 16'd300;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_reset_values();
      csr_read_check(sap_pkg::REG_DIVISOR, sap_pkg::DIVISOR_RST);
      csr_read_check(sap_pkg::REG_MAX_STEP, sap_pkg::MAX_STEP_RST);
      csr_read_check(sap_pkg::REG_MIN_STEP, sap_pkg::MIN_STEP_RST);
      csr_read_check(sap_pkg::REG_RATE_GAIN, sap_pkg::RATE_GAIN_RST);
      csr_read_check(sap_pkg::REG_ROUND_BIAS, sap_pkg::ROUND_BIAS_RST);
      send_word(REQ_STEP, 16'sd0);          // already there
      send_word(REQ_STEP, 16'sd100);
      send_word(REQ_STEP, 16'sh8000);       // lands past the positive rail
      wait_idle();
   endtask

   task automatic test_wrap_and_load();
      send_word(REQ_LOAD, 16'sh7FFF);
      send_word(REQ_STEP, 16'sh8000);       // difference wraps to +1
      send_word(REQ_LOAD, 16'sh8000);
      send_word(REQ_STEP, 16'sh7FFF);       // difference wraps to -1
      send_word(REQ_LOAD, 16'sd0);
      wait_idle();
   endtask

   task automatic test_zero_divisor();
      csr_write(sap_pkg::REG_DIVISOR, 32'd0);
      send_word(REQ_STEP, 16'sd5);          // error, value held
      send_word(REQ_LOAD, 16'sd77);         // load ignores the divisor
      send_word(REQ_STEP, 16'sd77);         // at target yet still an error
      send_word(REQ_STEP, -16'sd77);
      wait_idle();
   endtask

   task automatic test_divide_overflow();
      csr_write(sap_pkg::REG_DIVISOR, 32'h0000_FFFF);  // -1
      send_word(REQ_LOAD, 16'sd0);
      send_word(REQ_STEP, 16'sh8000);         // -32768 / -1 wraps
      wait_idle();
   endtask

   task automatic test_band_steps();
      // band of 50: small moves take the minimum step and snap onto the target
      apply_settings(32'd1, 32'd32767, 32'd50, 32'd4096, 32'd2048);
      send_word(REQ_LOAD, 16'sd0);
      send_word(REQ_STEP, 16'sd30);
      send_word(REQ_STEP, -16'sd30);
      send_word(REQ_STEP, -16'sd10);
      // zero step in band with full bias drifts by one the wrong way
      apply_settings(32'd32767, 32'd32767, 32'd0, 32'd4096, 32'd4096);
      send_word(REQ_LOAD, 16'sd0);
      send_word(REQ_STEP, 16'sd10);
      csr_write(sap_pkg::REG_ROUND_BIAS, 32'd2048);
      send_word(REQ_STEP, 16'sd10);
      wait_idle();
   endtask

   task automatic test_gain_bias_extremes();
      apply_settings(32'd1, 32'd0, 32'd0, 32'd65535, 32'hFFFF_F000);   // bias -4096
      send_word(REQ_LOAD, 16'sd0);
      send_word(REQ_STEP, 16'sd1000);
      // bias patterns beyond +/-4096 are taken as their low 14 bits, signed
      apply_settings(32'd3, 32'd32767, 32'd32767, 32'd0, 32'h0000_1FFF);
      send_word(REQ_STEP, -16'sd1000);
      apply_settings(32'h0000_8000, 32'd1, 32'd1, 32'd1, 32'h0000_2000);
      send_word(REQ_STEP, 16'sh7FFF);
      wait_idle();
   endtask

   // Each phase: new register setting, then runs of steps chasing one aim
   // (so the value actually converges and hits the band/snap paths),
   // with loads mixed in. One phase runs with no bubbles or stalls.
   task automatic test_random_phases();
      logic [31:0]        div;
      logic [31:0]        max_s;
      logic [31:0]        min_s;
      logic [31:0]        gain;
      logic [31:0]        bias;
      logic signed [15:0] aim;
      int                 sent;
      int                 run;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case ($urandom_range(9))
            0:       div = 32'd0;
            1:       div = 32'd1;
            2:       div = 32'h0000_FFFF;
            3:       div = 32'd32767;
            4:       div = 32'h0000_8000;
            5, 6:    div = $urandom_range(1) ? $urandom_range(1, 16) : -$urandom_range(1, 16);
            default: div = $urandom;
         endcase
         run = $urandom_range(99);
         if (run < 25)      max_s = 32'd32767;
         else if (run < 35) max_s = 32'd0;
         else if (run < 50) max_s = $urandom_range(1, 8);
         else               max_s = $urandom_range(0, 32767);
         run = $urandom_range(99);
         if (run < 30)      min_s = 32'd0;
         else if (run < 40) min_s = 32'd32767;
         else               min_s = $urandom_range(0, 200);
         run = $urandom_range(99);
         if (run < 30)      gain = 32'd4096;
         else if (run < 40) gain = 32'd0;
         else if (run < 50) gain = 32'd65535;
         else               gain = $urandom_range(0, 65535);
         run = $urandom_range(99);
         if (run < 20)      bias = 32'd2048;
         else if (run < 30) bias = 32'd4096;
         else if (run < 40) bias = -32'd4096;
         else if (run < 50) bias = $urandom;
         else               bias = $urandom_range(0, 8192) - 4096;
         if (p == 0) begin
            div   = sap_pkg::DIVISOR_RST;
            max_s = sap_pkg::MAX_STEP_RST;
            min_s = sap_pkg::MIN_STEP_RST;
            gain  = sap_pkg::RATE_GAIN_RST;
            bias  = 32'(sap_pkg::ROUND_BIAS_RST);
         end
         apply_settings(div, max_s, min_s, gain, bias);
         no_idle = (p == PHASE_COUNT / 2);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ($urandom_range(99) < 15) begin
               send_word(REQ_LOAD, pick_value());
               sent++;
            end else begin
               aim = pick_value();
               run = $urandom_range(1, 10);
               repeat (run) send_word(REQ_STEP, aim);
               sent += run;
            end
         end
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      fail_count     = 0;
      no_idle        = 1'b0;
      tracked_value  = '0;
      cfg_divisor    = sap_pkg::DIVISOR_RST;
      cfg_max_step   = sap_pkg::MAX_STEP_RST;
      cfg_min_step   = sap_pkg::MIN_STEP_RST;
      cfg_rate_gain  = sap_pkg::RATE_GAIN_RST;
      cfg_round_bias = sap_pkg::ROUND_BIAS_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_wrap_and_load();
      test_zero_divisor();
      test_divide_overflow();
      test_band_steps();
      test_gain_bias_extremes();
      test_random_phases();

      // let anything stray show up before judging
      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("s16_smooth_approach_limited test passed");
      else
         $display("s16_smooth_approach_limited test failed");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("s16_smooth_approach_limited test failed");
      $finish;
   end

endmodule

// File: files.f
src/sap_pkg.sv
src/sap_div.sv
src/sap_mul.sv
src/s16_smooth_approach_limited.sv
verif/s16_smooth_approach_limited_tb.sv
